// ----- rtl/pde_pkg.sv -----
// Package of the polynomial derivative evaluator: types, constants and the microcode table.
package pde_pkg;

  // Fractional bits of the Q16.16 point and the Q48.16 chains.
  localparam int FRAC_BITS = 16;
  // Highest degree that is processed; items above it are dropped.
  localparam int MAX_DEGREE = 255;
  // Default and upper limit for the number of derivative chains minus one.
  localparam int MAX_ORDER_DEF = 8;
  localparam int MAX_ORDER_LIM = 12;

  // Register index codes of the configuration port; the byte address is four times the
  // index, so the index is paddr[2].
  localparam logic REG_EVAL_POINT  = 1'b0;
  localparam logic REG_DERIV_ORDER = 1'b1;

  // Factorials 0! .. 12!, all below 2^31.
  localparam logic [31:0] FACT_TABLE [0:MAX_ORDER_LIM] = '{
    32'd1, 32'd1, 32'd2, 32'd6, 32'd24, 32'd120, 32'd720, 32'd5040,
    32'd40320, 32'd362880, 32'd3628800, 32'd39916800, 32'd479001600
  };

  // Control of the shared multiplier unit.
  typedef struct packed {
    logic lo_en;     // Load the low partial product.
    logic hi_en;     // Load the high partial product.
    logic frac_sel;  // Multiply by the point and drop FRAC_BITS, else by k! unshifted.
  } mul_ctrl_t;

  // Sequencing operation of one microcode step.
  typedef enum logic [1:0] {
    SEQ_ACCEPT = 2'd0,  // Wait for an item, then go to the target.
    SEQ_NEXT   = 2'd1,  // Go to the target.
    SEQ_LOOP   = 2'd2,  // Next chain, result scaling, or back to idle.
    SEQ_OUT    = 2'd3   // Wait for a free output register, then go to the target.
  } seq_op_t;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_MLO   = 3'd1;
  localparam step_t STEP_MHI   = 3'd2;
  localparam step_t STEP_NORM  = 3'd3;
  localparam step_t STEP_ADD   = 3'd4;
  localparam step_t STEP_FLO   = 3'd5;
  localparam step_t STEP_FHI   = 3'd6;
  localparam step_t STEP_FNORM = 3'd7;

  typedef struct packed {
    mul_ctrl_t mul;
    logic      prod_en;  // Register the normalized product.
    logic      add_en;   // Write the chain with feed plus product.
    logic      out_en;   // Load the result register.
    seq_op_t   seq;
    step_t     next;
  } ucode_t;

  // The microprogram: four steps per chain, three for the final scaling.
  function automatic ucode_t pde_ucode(input step_t step);
    ucode_t uc;
    uc = '0;
    unique case (step)
      STEP_IDLE: begin
        uc.seq = SEQ_ACCEPT; uc.next = STEP_MLO;
      end
      STEP_MLO: begin
        uc.mul = '{lo_en: 1'b1, hi_en: 1'b0, frac_sel: 1'b1};
        uc.seq = SEQ_NEXT; uc.next = STEP_MHI;
      end
      STEP_MHI: begin
        uc.mul = '{lo_en: 1'b0, hi_en: 1'b1, frac_sel: 1'b1};
        uc.seq = SEQ_NEXT; uc.next = STEP_NORM;
      end
      STEP_NORM: begin
        uc.mul = '{lo_en: 1'b0, hi_en: 1'b0, frac_sel: 1'b1};
        uc.prod_en = 1'b1;
        uc.seq = SEQ_NEXT; uc.next = STEP_ADD;
      end
      STEP_ADD: begin
        uc.add_en = 1'b1;
        uc.seq = SEQ_LOOP; uc.next = STEP_MLO;
      end
      STEP_FLO: begin
        uc.mul = '{lo_en: 1'b1, hi_en: 1'b0, frac_sel: 1'b0};
        uc.seq = SEQ_NEXT; uc.next = STEP_FHI;
      end
      STEP_FHI: begin
        uc.mul = '{lo_en: 1'b0, hi_en: 1'b1, frac_sel: 1'b0};
        uc.seq = SEQ_NEXT; uc.next = STEP_FNORM;
      end
      STEP_FNORM: begin
        uc.mul = '{lo_en: 1'b0, hi_en: 1'b0, frac_sel: 1'b0};
        uc.out_en = 1'b1;
        uc.seq = SEQ_OUT; uc.next = STEP_IDLE;
      end
      default: begin
        uc.seq = SEQ_NEXT; uc.next = STEP_IDLE;
      end
    endcase
    return uc;
  endfunction

endpackage

// ----- rtl/pde_mul_unit.sv -----
// Shared 64 by 32 bit multiplier in two partial products with floor shift and saturation.
module pde_mul_unit import pde_pkg::*; (
  input  logic               clk,
  input  mul_ctrl_t          ctrl,
  input  logic signed [63:0] mul_a,
  input  logic signed [31:0] mul_b,
  output logic signed [63:0] mul_q,
  output logic               mul_ovf
);

  logic signed [64:0] p_lo_r;
  logic signed [63:0] p_hi_r;
  logic signed [95:0] hi_ext;
  logic signed [95:0] lo_ext;
  logic signed [95:0] full;
  logic signed [95:0] shifted;
  logic               fits;

  // The low half is taken as unsigned, the high half carries the sign.
  always_ff @(posedge clk) begin
    if (ctrl.lo_en) begin
      p_lo_r <= $signed({1'b0, mul_a[31:0]}) * mul_b;
    end
    if (ctrl.hi_en) begin
      p_hi_r <= $signed(mul_a[63:32]) * mul_b;
    end
  end

  // An arithmetic shift of the exact product rounds toward minus infinity.
  assign hi_ext  = {p_hi_r, 32'b0};
  assign lo_ext  = {{31{p_lo_r[64]}}, p_lo_r};
  assign full    = hi_ext + lo_ext;
  assign shifted = ctrl.frac_sel ? (full >>> FRAC_BITS) : full;
  assign fits    = (&shifted[95:63]) | ~(|shifted[95:63]);

  always_comb begin
    if (fits) begin
      mul_q = shifted[63:0];
    end else if (shifted[95]) begin
      mul_q = {1'b1, 63'b0};
    end else begin
      mul_q = {1'b0, {63{1'b1}}};
    end
  end

  assign mul_ovf = ~fits;

endmodule

// ----- rtl/polynomial_derivative_evaluator_core.sv -----
// Top level of the polynomial derivative evaluator: microcode sequencer, chains and ports.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_coefficient[31:0], in_degree[7:0]
//   out      output     out_valid / out_ready  out_derivative_value[63:0], out_saturated
//   cfg      input      psel/penable/pwrite    paddr[2:0], pwdata[31:0], prdata[31:0]
//
// An item of degree d runs min(k, d) + 1 chains, where k is the clamped order; the
// degree-0 item then runs the k! scaling. Each chain goes through the one shared
// multiplier unit in two partial products, a normalize step and a saturating add,
// and each chain feeds the next.
// Reset is synchronous and active low; it clears the chains, the overflow and valid flags,
// the configuration registers and the step counter. The result register holds a finished
// item while the next items are taken; only the scaling step waits for it to be emptied.
module polynomial_derivative_evaluator_core import pde_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input items.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_coefficient,
  input  logic        [7:0]  in_degree,
  // Result items.
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_derivative_value,
  output logic               out_saturated,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [2:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  localparam int CIDX_W = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;

  logic signed [31:0] eval_point_r;
  logic        [3:0]  order_r;
  logic        [3:0]  k_eff;

  step_t              step_r, step_nxt;
  ucode_t             uc;

  logic signed [63:0] chain_r [MAX_ORDER + 1];
  logic [CIDX_W-1:0]  chain_idx_r, chain_idx_nxt;
  logic signed [63:0] feed_r;
  logic        [7:0]  degree_r;
  logic signed [63:0] prod_r;
  logic               overflow_seen_r;

  logic               out_valid_r;
  logic signed [63:0] out_value_r;
  logic               out_sat_r;

  logic               accept;
  logic               deg_ok;
  logic               more_chains;
  logic               out_free;
  logic               out_load;
  logic               cfg_wr;

  logic signed [31:0] mul_b;
  logic signed [63:0] mul_q;
  logic               mul_ovf;
  logic signed [64:0] sum_wide;
  logic signed [63:0] sum_nxt;
  logic               add_ovf;

  // ---------------------------------------------------------------------------
  // Config regs: user writes only while the block is idle; it does not enforce this.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_point_r <= '0;
      order_r      <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_EVAL_POINT:  eval_point_r <= pwdata;
        REG_DERIV_ORDER: order_r      <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_EVAL_POINT:  prdata = eval_point_r;
      REG_DERIV_ORDER: prdata = {28'b0, order_r};
      default:         prdata = '0;
    endcase
  end

  // Orders above MAX_ORDER are clamped to the last chain.
  assign k_eff = (order_r > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : order_r;

  // ---------------------------------------------------------------------------
  // Sequencer: the step counter addresses the microcode table.
  // ---------------------------------------------------------------------------
  assign uc       = pde_ucode(step_r);
  assign in_ready = (uc.seq == SEQ_ACCEPT);
  assign accept   = in_valid & in_ready;
  assign deg_ok   = {9'b0, in_degree} <= 17'(MAX_DEGREE);

  // Chain j+1 runs only if it exists for this order and the degree reaches it.
  assign more_chains = (4'(chain_idx_r) < k_eff) && (degree_r > 8'(chain_idx_r));

  assign out_free = ~out_valid_r | out_ready;
  assign out_load = uc.out_en & out_free;

  always_comb begin
    step_nxt      = step_r;
    chain_idx_nxt = chain_idx_r;
    unique case (uc.seq)
      SEQ_ACCEPT: begin
        // An item above the highest degree is taken and dropped.
        if (accept && deg_ok) begin
          step_nxt      = uc.next;
          chain_idx_nxt = '0;
        end
      end
      SEQ_NEXT: begin
        step_nxt = uc.next;
      end
      SEQ_LOOP: begin
        if (more_chains) begin
          step_nxt      = uc.next;
          chain_idx_nxt = chain_idx_r + 1'b1;
        end else if (degree_r != 8'd0) begin
          step_nxt = STEP_IDLE;
        end else begin
          // Last coefficient: scale the chain of the selected order.
          step_nxt      = STEP_FLO;
          chain_idx_nxt = CIDX_W'(k_eff);
        end
      end
      SEQ_OUT: begin
        if (out_free) begin
          step_nxt = uc.next;
        end
      end
      default: step_nxt = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_IDLE;
      chain_idx_r <= '0;
    end else begin
      step_r      <= step_nxt;
      chain_idx_r <= chain_idx_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath. The multiplier takes the chain at the current index and either the
  // point or k!; the normalized product is registered before the add.
  // ---------------------------------------------------------------------------
  assign mul_b = uc.mul.frac_sel ? eval_point_r : $signed(FACT_TABLE[k_eff]);

  pde_mul_unit u_mul (
    .clk     (clk),
    .ctrl    (uc.mul),
    .mul_a   (chain_r[chain_idx_r]),
    .mul_b   (mul_b),
    .mul_q   (mul_q),
    .mul_ovf (mul_ovf)
  );

  assign sum_wide = {feed_r[63], feed_r} + {prod_r[63], prod_r};
  assign add_ovf  = sum_wide[64] ^ sum_wide[63];

  always_comb begin
    if (!add_ovf) begin
      sum_nxt = sum_wide[63:0];
    end else if (sum_wide[64]) begin
      sum_nxt = {1'b1, 63'b0};
    end else begin
      sum_nxt = {1'b0, {63{1'b1}}};
    end
  end

  // Item payload and the feed of the next chain: the coefficient for chain 0,
  // then the new value of the chain just written.
  always_ff @(posedge clk) begin
    if (accept) begin
      degree_r <= in_degree;
    end
    if (accept) begin
      feed_r <= 64'(in_coefficient);
    end else if (uc.add_en) begin
      feed_r <= sum_nxt;
    end
    if (uc.prod_en) begin
      prod_r <= mul_q;
    end
  end

  // Chains and the overflow flag persist across items until the result is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MAX_ORDER; i++) begin
        chain_r[i] <= '0;
      end
      overflow_seen_r <= 1'b0;
    end else if (out_load) begin
      for (int i = 0; i <= MAX_ORDER; i++) begin
        chain_r[i] <= '0;
      end
      overflow_seen_r <= 1'b0;
    end else begin
      if (uc.add_en) begin
        chain_r[chain_idx_r] <= sum_nxt;
      end
      if ((uc.prod_en && mul_ovf) || (uc.add_en && add_ovf)) begin
        overflow_seen_r <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= mul_q;
      out_sat_r   <= overflow_seen_r | mul_ovf;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_derivative_value = out_value_r;
  assign out_saturated        = out_sat_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(chain_idx_r) <= MAX_ORDER)
    else $error("chain index beyond the last chain");

  a_clear_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && !overflow_seen_r && chain_r[0] == 64'sd0))
    else $error("chains or flag not cleared when the result was loaded");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && deg_ok) |=> (step_r == STEP_MLO && chain_idx_r == '0))
    else $error("accepted item did not start at chain zero");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step_r == STEP_FNORM))
    else $error("result appeared outside the scaling step");

endmodule
